>>> hdl/gzhp_pkg.sv
// Package: shared types, codes and helpers for the gzip header parser.
package gzhp_pkg;

   localparam logic [7:0] MAGIC0_BYTE   = 8'h1f;
   localparam logic [7:0] MAGIC1_BYTE   = 8'h8b;
   localparam logic [7:0] METHOD_DEFL   = 8'h08;
   localparam logic [7:0] FLAGS_RSVD    = 8'he0;
   localparam logic [15:0] FIXED_LEN    = 16'd6;
   localparam logic [15:0] HCRC_LEN     = 16'd2;

   // Stored flag bits (the header flags byte shifted right by one).
   localparam int FL_HCRC_BIT    = 0;
   localparam int FL_EXTRA_BIT   = 1;
   localparam int FL_NAME_BIT    = 2;
   localparam int FL_COMMENT_BIT = 3;

   typedef enum logic [3:0] {
      PH_MAGIC0  = 4'd0,
      PH_MAGIC1  = 4'd1,
      PH_METHOD  = 4'd2,
      PH_FLAGS   = 4'd3,
      PH_FIXED   = 4'd4,
      PH_XLEN0   = 4'd5,
      PH_XLEN1   = 4'd6,
      PH_EXTRA   = 4'd7,
      PH_NAME    = 4'd8,
      PH_COMMENT = 4'd9,
      PH_HCRC    = 4'd10,
      PH_PAYLOAD = 4'd11
   } phase_type;

   typedef enum logic [2:0] {
      ST_HEADER    = 3'd0,
      ST_PAYLOAD   = 3'd1,
      ST_BADMAGIC  = 3'd2,
      ST_BADMETHOD = 3'd3,
      ST_TRUNC     = 3'd4,
      ST_EMPTY     = 3'd5
   } status_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  flags;
      logic [15:0] skip;
      status_type  sticky;
   } state_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  payload;
      logic        done;
   } result_type;

   typedef struct packed {
      phase_type   phase;
      logic        load_hcrc;
      logic        done;
   } part_type;

   // Find the first flagged header part at or after 'from'.
   function automatic part_type enter_part(input phase_type from, input logic [3:0] flags);
      part_type p;
      p.phase     = PH_PAYLOAD;
      p.load_hcrc = 1'b0;
      p.done      = 1'b0;
      if (from <= PH_XLEN0 && flags[FL_EXTRA_BIT]) begin
         p.phase = PH_XLEN0;
      end else if (from <= PH_NAME && flags[FL_NAME_BIT]) begin
         p.phase = PH_NAME;
      end else if (from <= PH_COMMENT && flags[FL_COMMENT_BIT]) begin
         p.phase = PH_COMMENT;
      end else if (from <= PH_HCRC && flags[FL_HCRC_BIT]) begin
         p.phase     = PH_HCRC;
         p.load_hcrc = 1'b1;
      end else begin
         p.done = 1'b1;
      end
      return p;
   endfunction

endpackage

>>> hdl/gzhp_step.sv
// Combinational per-byte step: next parser state and the result for one transaction.
module gzhp_step (
   input  gzhp_pkg::state_type  cur,
   input  logic [7:0]           data_byte,
   input  logic                 end_of_data,
   input  logic                 restart,
   output gzhp_pkg::state_type  nxt,
   output gzhp_pkg::result_type res
);

   gzhp_pkg::state_type st;
   gzhp_pkg::part_type  part;
   logic [15:0]         skip_dec;
   logic [15:0]         xlen;

   always_comb begin
      st = cur;
      if (restart) begin
         st.phase  = gzhp_pkg::PH_MAGIC0;
         st.flags  = 4'd0;
         st.skip   = 16'd0;
         st.sticky = gzhp_pkg::ST_HEADER;
      end

      nxt         = st;
      res.status  = gzhp_pkg::ST_HEADER;
      res.payload = 8'd0;
      res.done    = 1'b0;
      skip_dec    = st.skip - 16'd1;
      xlen        = st.skip | {data_byte, 8'd0};
      part        = gzhp_pkg::enter_part(gzhp_pkg::PH_PAYLOAD, st.flags);

      if (st.sticky != gzhp_pkg::ST_HEADER) begin
         res.status = st.sticky;
      end else if (end_of_data) begin
         if (st.phase == gzhp_pkg::PH_MAGIC0 || st.phase >= gzhp_pkg::PH_PAYLOAD) begin
            res.status = gzhp_pkg::ST_EMPTY;
         end else begin
            res.status = gzhp_pkg::ST_TRUNC;
            nxt.sticky = gzhp_pkg::ST_TRUNC;
         end
      end else begin
         unique case (st.phase)
            gzhp_pkg::PH_MAGIC0: begin
               if (data_byte != gzhp_pkg::MAGIC0_BYTE) begin
                  res.status = gzhp_pkg::ST_BADMAGIC;
                  nxt.sticky = gzhp_pkg::ST_BADMAGIC;
               end else begin
                  nxt.phase = gzhp_pkg::PH_MAGIC1;
               end
            end
            gzhp_pkg::PH_MAGIC1: begin
               if (data_byte != gzhp_pkg::MAGIC1_BYTE) begin
                  res.status = gzhp_pkg::ST_BADMAGIC;
                  nxt.sticky = gzhp_pkg::ST_BADMAGIC;
               end else begin
                  nxt.phase = gzhp_pkg::PH_METHOD;
               end
            end
            gzhp_pkg::PH_METHOD: begin
               if (data_byte != gzhp_pkg::METHOD_DEFL) begin
                  res.status = gzhp_pkg::ST_BADMETHOD;
                  nxt.sticky = gzhp_pkg::ST_BADMETHOD;
               end else begin
                  nxt.phase = gzhp_pkg::PH_FLAGS;
               end
            end
            gzhp_pkg::PH_FLAGS: begin
               if ((data_byte & gzhp_pkg::FLAGS_RSVD) != 8'd0) begin
                  res.status = gzhp_pkg::ST_BADMETHOD;
                  nxt.sticky = gzhp_pkg::ST_BADMETHOD;
               end else begin
                  nxt.flags = data_byte[4:1];
                  nxt.skip  = gzhp_pkg::FIXED_LEN;
                  nxt.phase = gzhp_pkg::PH_FIXED;
               end
            end
            gzhp_pkg::PH_FIXED: begin
               nxt.skip = skip_dec;
               part     = gzhp_pkg::enter_part(gzhp_pkg::PH_XLEN0, st.flags);
               if (skip_dec == 16'd0) begin
                  nxt.phase = part.phase;
                  res.done  = part.done;
                  if (part.load_hcrc) nxt.skip = gzhp_pkg::HCRC_LEN;
               end
            end
            gzhp_pkg::PH_XLEN0: begin
               nxt.skip  = {8'd0, data_byte};
               nxt.phase = gzhp_pkg::PH_XLEN1;
            end
            gzhp_pkg::PH_XLEN1: begin
               nxt.skip = xlen;
               part     = gzhp_pkg::enter_part(gzhp_pkg::PH_NAME, st.flags);
               if (xlen == 16'd0) begin
                  nxt.phase = part.phase;
                  res.done  = part.done;
                  if (part.load_hcrc) nxt.skip = gzhp_pkg::HCRC_LEN;
               end else begin
                  nxt.phase = gzhp_pkg::PH_EXTRA;
               end
            end
            gzhp_pkg::PH_EXTRA: begin
               nxt.skip = skip_dec;
               part     = gzhp_pkg::enter_part(gzhp_pkg::PH_NAME, st.flags);
               if (skip_dec == 16'd0) begin
                  nxt.phase = part.phase;
                  res.done  = part.done;
                  if (part.load_hcrc) nxt.skip = gzhp_pkg::HCRC_LEN;
               end
            end
            gzhp_pkg::PH_NAME: begin
               part = gzhp_pkg::enter_part(gzhp_pkg::PH_COMMENT, st.flags);
               if (data_byte == 8'd0) begin
                  nxt.phase = part.phase;
                  res.done  = part.done;
                  if (part.load_hcrc) nxt.skip = gzhp_pkg::HCRC_LEN;
               end
            end
            gzhp_pkg::PH_COMMENT: begin
               part = gzhp_pkg::enter_part(gzhp_pkg::PH_HCRC, st.flags);
               if (data_byte == 8'd0) begin
                  nxt.phase = part.phase;
                  res.done  = part.done;
                  if (part.load_hcrc) nxt.skip = gzhp_pkg::HCRC_LEN;
               end
            end
            gzhp_pkg::PH_HCRC: begin
               nxt.skip = skip_dec;
               if (skip_dec == 16'd0) begin
                  nxt.phase = part.phase;
                  res.done  = part.done;
               end
            end
            default: begin
               // payload, and any unused phase code
               res.status  = gzhp_pkg::ST_PAYLOAD;
               res.payload = data_byte;
            end
         endcase
      end
   end

endmodule

>>> hdl/gzip_header_parser.sv
// Top level: gzip member header parser, one stream byte per transaction.
//
// Each request transaction carries one byte of a gzip stream (or an end-of-data
// mark) and produces exactly one response transaction: a status code, the
// payload byte when the byte lies past the header, and a header-done flag on
// the byte that completes the member header. The parser checks the magic bytes,
// requires deflate method with reserved flag bits clear, skips the fixed fields
// and any flagged extra field, name, comment and header CRC. Errors (bad magic,
// bad method or flags, truncation) stick until a transaction with restart set.
// Throughput is one byte per clock cycle unless response backpressure holds the
// flow. An accepted byte sits in the request register, then its response sits in
// the response register, with the whole per-byte state update done in a single
// combinational step between them. The response register decouples the sides:
// a new byte is taken while an earlier response waits to be taken, and
// backpressure on the response stalls the request side only when both registers
// are full.
module gzip_header_parser (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_data,
   input  logic       req_restart,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_payload_out,
   output logic       rsp_header_done
);

   // request register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_eod_ff, in_eod_in;
   logic       in_restart_ff, in_restart_in;

   // parser state
   gzhp_pkg::state_type state_ff, state_in;
   gzhp_pkg::state_type step_state;

   // response register
   logic                 out_valid_ff, out_valid_in;
   gzhp_pkg::result_type out_ff, out_in;
   gzhp_pkg::result_type step_result;

   logic advance;   // request register hands its transaction on this cycle
   logic req_take;

   // Advance when the response register is empty or being drained.
   assign advance   = !out_valid_ff || !rsp_stall;
   // Hold a new request only while a staged one cannot advance.
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   gzhp_step u_step (
      .cur         (state_ff),
      .data_byte   (in_byte_ff),
      .end_of_data (in_eod_ff),
      .restart     (in_restart_ff),
      .nxt         (step_state),
      .res         (step_result)
   );

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      in_eod_in     = in_eod_ff;
      in_restart_in = in_restart_ff;
      state_in      = state_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;

      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            // Commit the state update together with its response.
            state_in = step_state;
            out_in   = step_result;
         end
      end
      if (req_take) begin
         in_valid_in   = 1'b1;
         in_byte_in    = req_data_byte;
         in_eod_in     = req_end_of_data;
         in_restart_in = req_restart;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         state_ff.phase  <= gzhp_pkg::PH_MAGIC0;
         state_ff.flags  <= 4'd0;
         state_ff.skip   <= 16'd0;
         state_ff.sticky <= gzhp_pkg::ST_HEADER;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      in_byte_ff    <= in_byte_in;
      in_eod_ff     <= in_eod_in;
      in_restart_ff <= in_restart_in;
      out_ff        <= out_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_payload_out = out_ff.payload;
   assign rsp_header_done = out_ff.done;

endmodule

>>> hdl/gzhp_checker.sv
// Checker: port-level assertions for the gzip header parser, bound to the top level.
module gzhp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_payload_out,
   input logic       rsp_header_done
);

   // Payload bytes appear only on payload responses.
   a_payload_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_out != 8'd0 |->
         rsp_status == gzhp_pkg::ST_PAYLOAD)
      else $error("payload byte on non-payload response");

   // Header completion is a plain header-byte response.
   a_done_is_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_header_done |->
         rsp_status == gzhp_pkg::ST_HEADER && rsp_payload_out == 8'd0)
      else $error("header done on non-header response");

   // Status stays within defined codes.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= gzhp_pkg::ST_EMPTY)
      else $error("undefined status code");

   // Stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_payload_out) && $stable(rsp_header_done))
      else $error("stalled response changed");

endmodule

bind gzip_header_parser gzhp_checker u_gzhp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_payload_out (rsp_payload_out),
   .rsp_header_done (rsp_header_done)
);
